[design/xdec_pkg.sv]
// ----------------------------------------------------------------------------
// xdec_pkg
// Shared types, opcode constants and decode helpers for the i386 subset decoder.
// ----------------------------------------------------------------------------
package xdec_pkg;

	typedef enum logic [2:0] {
		PH_OP,
		PH_OP2,
		PH_MODRM,
		PH_SIB,
		PH_DISP,
		PH_IMM
	} phase_t;

	// Instruction kinds
	localparam logic [4:0] K_MOV_RM     = 5'd0;
	localparam logic [4:0] K_MOV_RI     = 5'd1;
	localparam logic [4:0] K_MOV_MI     = 5'd2;
	localparam logic [4:0] K_JCC_S      = 5'd3;
	localparam logic [4:0] K_JCC_N      = 5'd4;
	localparam logic [4:0] K_ALU_RM     = 5'd5;
	localparam logic [4:0] K_ALU_AI     = 5'd6;
	localparam logic [4:0] K_GRP1       = 5'd7;
	localparam logic [4:0] K_GRP2       = 5'd8;
	localparam logic [4:0] K_GRP3       = 5'd9;
	localparam logic [4:0] K_GRP4       = 5'd10;
	localparam logic [4:0] K_GRP5       = 5'd11;
	localparam logic [4:0] K_INCDEC     = 5'd12;
	localparam logic [4:0] K_PUSHPOP    = 5'd13;
	localparam logic [4:0] K_PUSH_IMM   = 5'd14;
	localparam logic [4:0] K_POP_RM     = 5'd15;
	localparam logic [4:0] K_PUSHAD     = 5'd16;
	localparam logic [4:0] K_LEA        = 5'd17;
	localparam logic [4:0] K_JMP        = 5'd18;
	localparam logic [4:0] K_RET        = 5'd19;
	localparam logic [4:0] K_NOP        = 5'd20;
	localparam logic [4:0] K_IMUL_RM    = 5'd21;
	localparam logic [4:0] K_IMUL_RMI   = 5'd22;

	// Opcode constants
	localparam logic [7:0] OP_ESC    = 8'h0f;
	localparam logic [7:0] OP_GRP1B  = 8'h80;
	localparam logic [7:0] OP_GRP1D  = 8'h81;
	localparam logic [7:0] OP_GRP1S  = 8'h83;
	localparam logic [7:0] OP_GRP4   = 8'hfe;
	localparam logic [7:0] OP_GRP5   = 8'hff;
	localparam logic [7:0] OP_POPRM  = 8'h8f;
	localparam logic [7:0] OP_LEA    = 8'h8d;
	localparam logic [7:0] OP_NOP    = 8'h90;
	localparam logic [7:0] OP_PUSH32 = 8'h68;
	localparam logic [7:0] OP_IMUL32 = 8'h69;
	localparam logic [7:0] OP_JMP32  = 8'he9;
	localparam logic [7:0] OP_IMUL2  = 8'haf;
	localparam logic [7:0] OP_SHF1   = 8'hd0;
	localparam logic [7:0] OP_SHFCL  = 8'hd2;
	localparam logic [7:0] OP_SHFI   = 8'hc0;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  op;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [31:0] disp;
		logic [31:0] imm;
		logic [2:0]  left;
		logic [3:0]  len;
		logic [4:0]  kind;
	} dec_state_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [3:0]  sub;
		logic        wide;
		logic [2:0]  reg_f;
		logic [1:0]  mod_f;
		logic [2:0]  rm_f;
		logic        has_sib;
		logic [7:0]  sib;
		logic [31:0] disp;
		logic [31:0] imm;
		logic [3:0]  len;
		logic        bad;
	} dec_rec_t;

	function automatic logic uses_modrm(input logic [4:0] k);
		return k == K_MOV_RM || k == K_MOV_MI || k == K_ALU_RM ||
			(k >= K_GRP1 && k <= K_GRP5) || k == K_POP_RM || k == K_LEA ||
			k == K_IMUL_RM || k == K_IMUL_RMI;
	endfunction

	// Returns {known, kind} for a first opcode byte
	function automatic logic [5:0] decode_first(input logic [7:0] b);
		logic [5:0] r;
		r = 6'd0;
		priority if ((b & 8'hfc) == 8'h88) r = {1'b1, K_MOV_RM};
		else if ((b & 8'hf0) == 8'hb0) r = {1'b1, K_MOV_RI};
		else if ((b & 8'hfe) == 8'hc6) r = {1'b1, K_MOV_MI};
		else if ((b & 8'hf0) == 8'h70) r = {1'b1, K_JCC_S};
		else if ((b & 8'hc4) == 8'h00) r = {1'b1, K_ALU_RM};
		else if ((b & 8'hc6) == 8'h04) r = {1'b1, K_ALU_AI};
		else if ((b & 8'hfe) == OP_GRP1B || b == OP_GRP1S) r = {1'b1, K_GRP1};
		else if ((b & 8'hfc) == OP_SHF1 || (b & 8'hfe) == OP_SHFI) r = {1'b1, K_GRP2};
		else if ((b & 8'hfe) == 8'hf6) r = {1'b1, K_GRP3};
		else if (b == OP_GRP4) r = {1'b1, K_GRP4};
		else if (b == OP_GRP5) r = {1'b1, K_GRP5};
		else if ((b & 8'hf0) == 8'h40) r = {1'b1, K_INCDEC};
		else if ((b & 8'hf0) == 8'h50) r = {1'b1, K_PUSHPOP};
		else if ((b & 8'hfd) == OP_PUSH32) r = {1'b1, K_PUSH_IMM};
		else if (b == OP_POPRM) r = {1'b1, K_POP_RM};
		else if ((b & 8'hfe) == 8'h60) r = {1'b1, K_PUSHAD};
		else if (b == OP_LEA) r = {1'b1, K_LEA};
		else if ((b & 8'hfd) == OP_JMP32) r = {1'b1, K_JMP};
		else if ((b & 8'hf6) == 8'hc2) r = {1'b1, K_RET};
		else if (b == OP_NOP) r = {1'b1, K_NOP};
		else if ((b & 8'hfd) == OP_IMUL32) r = {1'b1, K_IMUL_RMI};
		else r = 6'd0;
		return r;
	endfunction

	function automatic logic [2:0] disp_size(input logic [4:0] k, input logic [7:0] op,
			input logic [7:0] m, input logic [7:0] s);
		logic [2:0] n;
		n = 3'd0;
		if (k == K_JCC_S) n = 3'd1;
		else if (k == K_JCC_N) n = 3'd4;
		else if (k == K_JMP) n = (op == OP_JMP32) ? 3'd4 : 3'd1;
		else if (uses_modrm(k)) begin
			unique case (m[7:6])
				2'd0: begin
					if (m[2:0] == 3'd5) n = 3'd4;
					else if (m[2:0] == 3'd4 && s[2:0] == 3'd5) n = 3'd4;
				end
				2'd1: n = 3'd1;
				2'd2: n = 3'd4;
				default: n = 3'd0;
			endcase
		end
		return n;
	endfunction

	function automatic logic [2:0] imm_size(input logic [4:0] k, input logic [7:0] op,
			input logic [7:0] m);
		logic [2:0] n;
		n = 3'd0;
		if (k == K_MOV_RI) n = op[3] ? 3'd4 : 3'd1;
		else if (k == K_MOV_MI || k == K_ALU_AI) n = op[0] ? 3'd4 : 3'd1;
		else if (k == K_GRP1) n = (op == OP_GRP1D) ? 3'd4 : 3'd1;
		else if (k == K_GRP2) n = ((op & 8'hfe) == OP_SHFI) ? 3'd1 : 3'd0;
		else if (k == K_GRP3) n = (m[5:3] == 3'd0) ? (op[0] ? 3'd4 : 3'd1) : 3'd0;
		else if (k == K_PUSH_IMM) n = (op == OP_PUSH32) ? 3'd4 : 3'd1;
		else if (k == K_RET) n = op[0] ? 3'd0 : 3'd2;
		else if (k == K_IMUL_RMI) n = (op == OP_IMUL32) ? 3'd4 : 3'd1;
		return n;
	endfunction

	function automatic logic reserved_sub(input logic [4:0] k, input logic [7:0] m);
		logic [2:0] r;
		logic       v;
		r = m[5:3];
		v = 1'b0;
		if (k == K_MOV_MI || k == K_POP_RM) v = (r != 3'd0);
		else if (k == K_GRP2) v = (r == 3'd6);
		else if (k == K_GRP3) v = (r == 3'd1);
		else if (k == K_GRP4) v = (r > 3'd1);
		else if (k == K_GRP5) v = (r == 3'd3 || r == 3'd5 || r == 3'd7);
		return v;
	endfunction

	// Place one byte of a little-endian field; sign-extend single-byte fields
	function automatic logic [31:0] collect(input logic [31:0] acc, input logic [2:0] size,
			input logic [2:0] left, input logic [7:0] b);
		logic [1:0]  idx;
		logic [31:0] a;
		idx = 2'(size - left);
		a = acc | ({24'd0, b} << {idx, 3'd0});
		if (left == 3'd1 && size == 3'd1 && a[7]) a = a | 32'hffffff00;
		return a;
	endfunction

endpackage

[design/xdec_step.sv]
// ----------------------------------------------------------------------------
// xdec_step
// Per-byte next-state logic: advances the field collector and forms a record.
// ----------------------------------------------------------------------------
module xdec_step (
	input  xdec_pkg::dec_state_t st,
	input  logic [7:0]           b,
	output xdec_pkg::dec_state_t ns,
	output logic                 emit,
	output xdec_pkg::dec_rec_t   rec
);

	logic       bad;
	logic       do_addr;
	logic       do_after_disp;
	logic       do_emit;
	logic [5:0] first;
	logic [2:0] dsz;
	logic [2:0] isz;
	logic [2:0] n_disp;
	logic [2:0] n_imm;

	assign first = xdec_pkg::decode_first(b);
	assign dsz   = xdec_pkg::disp_size(st.kind, st.op, st.modrm, st.sib);
	assign isz   = xdec_pkg::imm_size(st.kind, st.op, st.modrm);

	// Advance the collector by one byte
	always_comb begin
		ns            = st;
		bad           = 1'b0;
		do_addr       = 1'b0;
		do_after_disp = 1'b0;
		do_emit       = 1'b0;
		n_disp        = 3'd0;
		n_imm         = 3'd0;
		if (st.phase == xdec_pkg::PH_OP) begin
			ns.op    = b;
			ns.modrm = 8'd0;
			ns.sib   = 8'd0;
			ns.disp  = 32'd0;
			ns.imm   = 32'd0;
			ns.left  = 3'd0;
			ns.len   = 4'd1;
			ns.kind  = 5'd0;
		end else begin
			ns.len = st.len + 4'd1;
		end
		unique case (st.phase)
			xdec_pkg::PH_OP: begin
				if (b == xdec_pkg::OP_ESC) ns.phase = xdec_pkg::PH_OP2;
				else if (!first[5]) bad = 1'b1;
				else begin
					ns.kind = first[4:0];
					if (xdec_pkg::uses_modrm(first[4:0])) ns.phase = xdec_pkg::PH_MODRM;
					else do_addr = 1'b1;
				end
			end
			xdec_pkg::PH_OP2: begin
				if (b[7:4] == 4'h8) begin
					ns.op   = b;
					ns.kind = xdec_pkg::K_JCC_N;
					do_addr = 1'b1;
				end else if (b == xdec_pkg::OP_IMUL2) begin
					ns.op    = b;
					ns.kind  = xdec_pkg::K_IMUL_RM;
					ns.phase = xdec_pkg::PH_MODRM;
				end else begin
					bad = 1'b1;
				end
			end
			xdec_pkg::PH_MODRM: begin
				ns.modrm = b;
				if (xdec_pkg::reserved_sub(st.kind, b)) bad = 1'b1;
				else if (b[7:6] != 2'd3 && b[2:0] == 3'd4) ns.phase = xdec_pkg::PH_SIB;
				else do_addr = 1'b1;
			end
			xdec_pkg::PH_SIB: begin
				ns.sib  = b;
				do_addr = 1'b1;
			end
			xdec_pkg::PH_DISP: begin
				ns.disp = xdec_pkg::collect(st.disp, dsz, st.left, b);
				ns.left = (st.left != 3'd0) ? st.left - 3'd1 : 3'd0;
				if (ns.left == 3'd0) do_after_disp = 1'b1;
			end
			xdec_pkg::PH_IMM: begin
				ns.imm  = xdec_pkg::collect(st.imm, isz, st.left, b);
				ns.left = (st.left != 3'd0) ? st.left - 3'd1 : 3'd0;
				if (ns.left == 3'd0) do_emit = 1'b1;
			end
			default: bad = 1'b1;
		endcase
		// Chain through address, displacement and immediate sizing
		if (do_addr) begin
			n_disp = xdec_pkg::disp_size(ns.kind, ns.op, ns.modrm, ns.sib);
			if (n_disp != 3'd0) begin
				ns.phase = xdec_pkg::PH_DISP;
				ns.left  = n_disp;
			end else begin
				do_after_disp = 1'b1;
			end
		end
		if (do_after_disp) begin
			n_imm = xdec_pkg::imm_size(ns.kind, ns.op, ns.modrm);
			if (n_imm != 3'd0) begin
				ns.phase = xdec_pkg::PH_IMM;
				ns.left  = n_imm;
			end else begin
				do_emit = 1'b1;
			end
		end
		if (bad || do_emit) ns.phase = xdec_pkg::PH_OP;
	end

	assign emit = bad || do_emit;

	// Form the result record
	always_comb begin
		logic [7:0] op;
		logic [7:0] m;
		logic [4:0] k;
		op  = ns.op;
		k   = ns.kind;
		m   = xdec_pkg::uses_modrm(k) ? ns.modrm : 8'd0;
		rec = '0;
		rec.kind    = k;
		rec.reg_f   = m[5:3];
		rec.mod_f   = m[7:6];
		rec.rm_f    = m[2:0];
		rec.has_sib = xdec_pkg::uses_modrm(k) && m[7:6] != 2'd3 && m[2:0] == 3'd4;
		rec.sib     = rec.has_sib ? ns.sib : 8'd0;
		rec.disp    = ns.disp;
		rec.imm     = ns.imm;
		rec.len     = ns.len;
		unique case (k)
			xdec_pkg::K_MOV_RM:   begin rec.sub = {op[1], 3'd0}; rec.wide = op[0]; end
			xdec_pkg::K_MOV_RI:   begin rec.sub = {1'b0, op[2:0]}; rec.wide = op[3]; end
			xdec_pkg::K_MOV_MI:   rec.wide = op[0];
			xdec_pkg::K_JCC_S:    rec.sub = op[3:0];
			xdec_pkg::K_JCC_N:    begin rec.sub = op[3:0]; rec.wide = 1'b1; end
			xdec_pkg::K_ALU_RM:   begin rec.sub = {op[1], op[5:3]}; rec.wide = op[0]; end
			xdec_pkg::K_ALU_AI:   begin rec.sub = {1'b0, op[5:3]}; rec.wide = op[0]; end
			xdec_pkg::K_GRP1: begin
				rec.sub  = {op == xdec_pkg::OP_GRP1S, m[5:3]};
				rec.wide = op != xdec_pkg::OP_GRP1B;
			end
			xdec_pkg::K_GRP2: begin
				rec.sub  = {(op & 8'hfe) == xdec_pkg::OP_SHFCL, m[5:3]};
				rec.wide = op[0];
				if ((op & 8'hfe) == xdec_pkg::OP_SHF1) rec.imm = 32'd1;
			end
			xdec_pkg::K_GRP3:     begin rec.sub = {1'b0, m[5:3]}; rec.wide = op[0]; end
			xdec_pkg::K_GRP4:     rec.sub = {1'b0, m[5:3]};
			xdec_pkg::K_GRP5:     begin rec.sub = {1'b0, m[5:3]}; rec.wide = 1'b1; end
			xdec_pkg::K_INCDEC,
			xdec_pkg::K_PUSHPOP,
			xdec_pkg::K_RET:      begin rec.sub = op[3:0]; rec.wide = 1'b1; end
			xdec_pkg::K_PUSH_IMM: rec.wide = op == xdec_pkg::OP_PUSH32;
			xdec_pkg::K_PUSHAD:   begin rec.sub = {3'd0, op[0]}; rec.wide = 1'b1; end
			xdec_pkg::K_JMP:      rec.wide = op == xdec_pkg::OP_JMP32;
			xdec_pkg::K_NOP:      rec.wide = 1'b0;
			xdec_pkg::K_IMUL_RMI: begin rec.sub = {3'd0, op[1]}; rec.wide = 1'b1; end
			default:              rec.wide = 1'b1;
		endcase
		// A bad record carries only its length and the bad flag
		if (bad) begin
			rec     = '0;
			rec.len = ns.len;
			rec.bad = 1'b1;
		end
	end

endmodule

[design/x86_subset_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// x86_subset_instruction_decoder
// Byte-stream decoder for a subset of i386 instructions.
// ----------------------------------------------------------------------------
// Code bytes enter in address order, one per cycle unless stalled, through a
// byte register; the byte is decoded against the held instruction state and,
// when it ends an instruction, one record (kind, subcode, ModRM/SIB fields,
// displacement, immediate, length) lands in the result register, which drives
// the outputs. Bytes that cannot start an instruction, unknown bytes after the
// 0F escape, or reserved ModRM subcodes, give a record with bad_opcode set;
// decoding then resumes at the next byte. A new byte can be taken every cycle;
// the input stalls only while a byte is held and a finished record is stalled.
module x86_subset_instruction_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         code_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         inst_kind,
	output logic [3:0]         sub_op,
	output logic               operand_wide,
	output logic [2:0]         reg_field,
	output logic [1:0]         mod_field,
	output logic [2:0]         rm_field,
	output logic               has_sib,
	output logic [7:0]         sib_byte,
	output logic signed [31:0] displacement,
	output logic signed [31:0] immediate,
	output logic [3:0]         inst_length,
	output logic               bad_opcode
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	xdec_pkg::dec_state_t state_q;
	xdec_pkg::dec_state_t state_next;
	logic                 emit;
	xdec_pkg::dec_rec_t   rec;
	logic                 out_valid_q;
	xdec_pkg::dec_rec_t   rec_q;
	logic                 go;

	// Decode the held byte whenever the result register can take a record
	assign go       = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	xdec_step u_step (
		.st   (state_q),
		.b    (byte_s1),
		.ns   (state_next),
		.emit (emit),
		.rec  (rec)
	);

	// Hold the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= code_byte;
		end
	end

	// Advance the decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: xdec_pkg::PH_OP, default: '0};
		end else if (go) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			rec_q <= rec;
		end
	end

	assign out_valid    = out_valid_q;
	assign inst_kind    = rec_q.kind;
	assign sub_op       = rec_q.sub;
	assign operand_wide = rec_q.wide;
	assign reg_field    = rec_q.reg_f;
	assign mod_field    = rec_q.mod_f;
	assign rm_field     = rec_q.rm_f;
	assign has_sib      = rec_q.has_sib;
	assign sib_byte     = rec_q.sib;
	assign displacement = rec_q.disp;
	assign immediate    = rec_q.imm;
	assign inst_length  = rec_q.len;
	assign bad_opcode   = rec_q.bad;

`ifndef ASSERT_OFF
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && valid_s1))
		else $error("input stalled without a waiting record");
	a_bad_short: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rec_q.bad) |-> (rec_q.len == 4'd1 || rec_q.len == 4'd2))
		else $error("bad record longer than two bytes");
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (rec_q.len != 4'd0))
		else $error("record with zero length");
	a_opcode_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emit) |=> (state_q.phase == xdec_pkg::PH_OP))
		else $error("decoder not back at opcode after a record");
`endif

endmodule

[tb/x86_subset_instruction_decoder_test.sv]
// ----------------------------------------------------------------------------
// x86_subset_instruction_decoder_test
// Streams code bytes into the decoder and checks every instruction record
// against a behavioural decoder, with random idling on both channels.
// ----------------------------------------------------------------------------
module x86_subset_instruction_decoder_test;

	typedef struct {
		logic [4:0]  kind;
		logic [3:0]  sub;
		logic        wide;
		logic [2:0]  reg_f;
		logic [1:0]  mod_f;
		logic [2:0]  rm_f;
		logic        has_sib;
		logic [7:0]  sib;
		logic [31:0] disp;
		logic [31:0] imm;
		logic [3:0]  len;
		logic        bad;
	} inst_rec_t;

	typedef enum int {BAD_NONE, BAD_LEN1, BAD_LEN2} bad_kind_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [7:0] code_byte;
	logic [4:0] inst_kind;
	logic [3:0] sub_op, inst_length;
	logic operand_wide, has_sib, bad_opcode;
	logic [2:0] reg_field, rm_field;
	logic [1:0] mod_field;
	logic [7:0] sib_byte;
	logic signed [31:0] displacement, immediate;

	x86_subset_instruction_decoder i_dut (.*);

	// decoder shadow state
	xdec_pkg::phase_t dp_phase;
	logic [7:0]  dp_op, dp_modrm, dp_sib;
	logic [31:0] dp_disp, dp_imm;
	logic [2:0]  dp_left;
	logic [3:0]  dp_len;
	logic [4:0]  dp_kind;

	inst_rec_t expected_records[$];
	bad_kind_t expected_bad_kinds[$];
	int mismatches, cycle_count;
	int send_idle_pct, recv_idle_pct;
	bit hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit has_modrm(logic [4:0] k);
		return k == xdec_pkg::K_MOV_RM || k == xdec_pkg::K_MOV_MI ||
			k == xdec_pkg::K_ALU_RM ||
			(k >= xdec_pkg::K_GRP1 && k <= xdec_pkg::K_GRP5) ||
			k == xdec_pkg::K_POP_RM || k == xdec_pkg::K_LEA ||
			k == xdec_pkg::K_IMUL_RM || k == xdec_pkg::K_IMUL_RMI;
	endfunction

	function automatic int first_kind(logic [7:0] b);
		if ((b & 8'hfc) == 8'h88) return xdec_pkg::K_MOV_RM;
		if ((b & 8'hf0) == 8'hb0) return xdec_pkg::K_MOV_RI;
		if ((b & 8'hfe) == 8'hc6) return xdec_pkg::K_MOV_MI;
		if ((b & 8'hf0) == 8'h70) return xdec_pkg::K_JCC_S;
		if ((b & 8'hc4) == 8'h00) return xdec_pkg::K_ALU_RM;
		if ((b & 8'hc6) == 8'h04) return xdec_pkg::K_ALU_AI;
		if ((b & 8'hfe) == xdec_pkg::OP_GRP1B || b == xdec_pkg::OP_GRP1S)
			return xdec_pkg::K_GRP1;
		if ((b & 8'hfc) == xdec_pkg::OP_SHF1 || (b & 8'hfe) == xdec_pkg::OP_SHFI)
			return xdec_pkg::K_GRP2;
		if ((b & 8'hfe) == 8'hf6) return xdec_pkg::K_GRP3;
		if (b == xdec_pkg::OP_GRP4) return xdec_pkg::K_GRP4;
		if (b == xdec_pkg::OP_GRP5) return xdec_pkg::K_GRP5;
		if ((b & 8'hf0) == 8'h40) return xdec_pkg::K_INCDEC;
		if ((b & 8'hf0) == 8'h50) return xdec_pkg::K_PUSHPOP;
		if ((b & 8'hfd) == xdec_pkg::OP_PUSH32) return xdec_pkg::K_PUSH_IMM;
		if (b == xdec_pkg::OP_POPRM) return xdec_pkg::K_POP_RM;
		if ((b & 8'hfe) == 8'h60) return xdec_pkg::K_PUSHAD;
		if (b == xdec_pkg::OP_LEA) return xdec_pkg::K_LEA;
		if ((b & 8'hfd) == xdec_pkg::OP_JMP32) return xdec_pkg::K_JMP;
		if ((b & 8'hf6) == 8'hc2) return xdec_pkg::K_RET;
		if (b == xdec_pkg::OP_NOP) return xdec_pkg::K_NOP;
		if ((b & 8'hfd) == xdec_pkg::OP_IMUL32) return xdec_pkg::K_IMUL_RMI;
		return -1;
	endfunction

	function automatic int disp_bytes();
		if (dp_kind == xdec_pkg::K_JCC_S) return 1;
		if (dp_kind == xdec_pkg::K_JCC_N) return 4;
		if (dp_kind == xdec_pkg::K_JMP) return dp_op == xdec_pkg::OP_JMP32 ? 4 : 1;
		if (!has_modrm(dp_kind)) return 0;
		case (dp_modrm[7:6])
			2'd0: return (dp_modrm[2:0] == 3'd5 ||
				(dp_modrm[2:0] == 3'd4 && dp_sib[2:0] == 3'd5)) ? 4 : 0;
			2'd1: return 1;
			2'd2: return 4;
			default: return 0;
		endcase
	endfunction

	function automatic int imm_bytes();
		case (dp_kind)
			xdec_pkg::K_MOV_RI: return dp_op[3] ? 4 : 1;
			xdec_pkg::K_MOV_MI, xdec_pkg::K_ALU_AI: return dp_op[0] ? 4 : 1;
			xdec_pkg::K_GRP1: return dp_op == xdec_pkg::OP_GRP1D ? 4 : 1;
			xdec_pkg::K_GRP2: return (dp_op & 8'hfe) == xdec_pkg::OP_SHFI ? 1 : 0;
			xdec_pkg::K_GRP3: return dp_modrm[5:3] == 3'd0 ? (dp_op[0] ? 4 : 1) : 0;
			xdec_pkg::K_PUSH_IMM: return dp_op == xdec_pkg::OP_PUSH32 ? 4 : 1;
			xdec_pkg::K_RET: return dp_op[0] ? 0 : 2;
			xdec_pkg::K_IMUL_RMI: return dp_op == xdec_pkg::OP_IMUL32 ? 4 : 1;
			default: return 0;
		endcase
	endfunction

	function automatic bit is_reserved();
		logic [2:0] r;
		r = dp_modrm[5:3];
		case (dp_kind)
			xdec_pkg::K_MOV_MI, xdec_pkg::K_POP_RM: return r != 3'd0;
			xdec_pkg::K_GRP2: return r == 3'd6;
			xdec_pkg::K_GRP3: return r == 3'd1;
			xdec_pkg::K_GRP4: return r > 3'd1;
			xdec_pkg::K_GRP5: return r == 3'd3 || r == 3'd5 || r == 3'd7;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [31:0] place_byte(logic [31:0] acc, int size, logic [7:0] b);
		logic [31:0] a;
		a = acc | (32'(b) << (8 * ((size - dp_left) & 3)));
		if (dp_left == 3'd1 && size == 1 && a[7]) a |= 32'hffffff00;
		return a;
	endfunction

	function automatic inst_rec_t bad_record();
		inst_rec_t r;
		r = '{default: '0};
		r.len = dp_len;
		r.bad = 1'b1;
		dp_phase = xdec_pkg::PH_OP;
		return r;
	endfunction

	function automatic inst_rec_t finished_record();
		inst_rec_t r;
		logic [7:0] m;
		logic [7:0] op;
		bit sib_on;
		r = '{default: '0};
		op = dp_op;
		m = has_modrm(dp_kind) ? dp_modrm : 8'h00;
		sib_on = has_modrm(dp_kind) && dp_modrm[7:6] != 2'd3 && dp_modrm[2:0] == 3'd4;
		r.imm = dp_imm;
		case (dp_kind)
			xdec_pkg::K_MOV_RM: begin r.sub = {op[1], 3'd0}; r.wide = op[0]; end
			xdec_pkg::K_MOV_RI: begin r.sub = {1'b0, op[2:0]}; r.wide = op[3]; end
			xdec_pkg::K_MOV_MI: r.wide = op[0];
			xdec_pkg::K_JCC_S: r.sub = op[3:0];
			xdec_pkg::K_JCC_N: begin r.sub = op[3:0]; r.wide = 1'b1; end
			xdec_pkg::K_ALU_RM: begin r.sub = {op[1], op[5:3]}; r.wide = op[0]; end
			xdec_pkg::K_ALU_AI: begin r.sub = {1'b0, op[5:3]}; r.wide = op[0]; end
			xdec_pkg::K_GRP1: begin
				r.sub = {op == xdec_pkg::OP_GRP1S, dp_modrm[5:3]};
				r.wide = op != xdec_pkg::OP_GRP1B;
			end
			xdec_pkg::K_GRP2: begin
				r.sub = {(op & 8'hfe) == xdec_pkg::OP_SHFCL, dp_modrm[5:3]};
				r.wide = op[0];
				if ((op & 8'hfe) == xdec_pkg::OP_SHF1) r.imm = 32'd1;
			end
			xdec_pkg::K_GRP3: begin r.sub = {1'b0, dp_modrm[5:3]}; r.wide = op[0]; end
			xdec_pkg::K_GRP4: r.sub = {1'b0, dp_modrm[5:3]};
			xdec_pkg::K_GRP5: begin r.sub = {1'b0, dp_modrm[5:3]}; r.wide = 1'b1; end
			xdec_pkg::K_INCDEC, xdec_pkg::K_PUSHPOP, xdec_pkg::K_RET: begin
				r.sub = op[3:0];
				r.wide = 1'b1;
			end
			xdec_pkg::K_PUSH_IMM: r.wide = op == xdec_pkg::OP_PUSH32;
			xdec_pkg::K_PUSHAD: begin r.sub = {3'd0, op[0]}; r.wide = 1'b1; end
			xdec_pkg::K_JMP: r.wide = op == xdec_pkg::OP_JMP32;
			xdec_pkg::K_NOP: ;
			xdec_pkg::K_IMUL_RMI: begin r.sub = {3'd0, op[1]}; r.wide = 1'b1; end
			default: r.wide = 1'b1;
		endcase
		r.kind = dp_kind;
		r.reg_f = m[5:3];
		r.mod_f = m[7:6];
		r.rm_f = m[2:0];
		r.has_sib = sib_on;
		r.sib = sib_on ? dp_sib : 8'h00;
		r.disp = dp_disp;
		r.len = dp_len;
		dp_phase = xdec_pkg::PH_OP;
		return r;
	endfunction

	// continue after the displacement: immediate bytes or the record
	function automatic bit after_displacement(output inst_rec_t r);
		int n;
		n = imm_bytes();
		if (n != 0) begin
			dp_phase = xdec_pkg::PH_IMM;
			dp_left = 3'(n);
			return 1'b0;
		end
		r = finished_record();
		return 1'b1;
	endfunction

	function automatic bit after_address(output inst_rec_t r);
		int n;
		n = disp_bytes();
		if (n != 0) begin
			dp_phase = xdec_pkg::PH_DISP;
			dp_left = 3'(n);
			return 1'b0;
		end
		return after_displacement(r);
	endfunction

	// advance the shadow decoder by one byte; returns 1 when a record is due
	function automatic bit decode_byte(logic [7:0] b, output inst_rec_t r);
		int k;
		r = '{default: '0};
		if (dp_phase == xdec_pkg::PH_OP) begin
			dp_op = b;
			dp_modrm = '0;
			dp_sib = '0;
			dp_disp = '0;
			dp_imm = '0;
			dp_left = '0;
			dp_len = 4'd1;
			dp_kind = '0;
			if (b == xdec_pkg::OP_ESC) begin
				dp_phase = xdec_pkg::PH_OP2;
				return 1'b0;
			end
			k = first_kind(b);
			if (k < 0) begin
				r = bad_record();
				return 1'b1;
			end
			dp_kind = 5'(k);
			if (has_modrm(dp_kind)) begin
				dp_phase = xdec_pkg::PH_MODRM;
				return 1'b0;
			end
			return after_address(r);
		end
		dp_len = dp_len + 4'd1;
		case (dp_phase)
			xdec_pkg::PH_OP2: begin
				if (b[7:4] == 4'h8) begin
					dp_op = b;
					dp_kind = xdec_pkg::K_JCC_N;
					return after_address(r);
				end
				if (b == xdec_pkg::OP_IMUL2) begin
					dp_op = b;
					dp_kind = xdec_pkg::K_IMUL_RM;
					dp_phase = xdec_pkg::PH_MODRM;
					return 1'b0;
				end
				r = bad_record();
				return 1'b1;
			end
			xdec_pkg::PH_MODRM: begin
				dp_modrm = b;
				if (is_reserved()) begin
					r = bad_record();
					return 1'b1;
				end
				if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
					dp_phase = xdec_pkg::PH_SIB;
					return 1'b0;
				end
				return after_address(r);
			end
			xdec_pkg::PH_SIB: begin
				dp_sib = b;
				return after_address(r);
			end
			xdec_pkg::PH_DISP: begin
				dp_disp = place_byte(dp_disp, disp_bytes(), b);
				if (dp_left > 0) dp_left--;
				if (dp_left == 0) return after_displacement(r);
				return 1'b0;
			end
			xdec_pkg::PH_IMM: begin
				dp_imm = place_byte(dp_imm, imm_bytes(), b);
				if (dp_left > 0) dp_left--;
				if (dp_left == 0) begin
					r = finished_record();
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				r = bad_record();
				return 1'b1;
			end
		endcase
	endfunction

	// drive one byte and wait for its acceptance
	task automatic send_byte(logic [7:0] b, bad_kind_t bad_at_glance = BAD_NONE);
		inst_rec_t r;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (decode_byte(b, r)) begin
			expected_records.push_back(r);
			expected_bad_kinds.push_back(bad_at_glance);
		end
		@(negedge clk);
	endtask

	task automatic send_field(int n, logic [31:0] v);
		for (int i = 0; i < n; i++) send_byte(v[8 * i +: 8]);
	endtask

	function automatic logic [7:0] random_opcode();
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while (first_kind(b) < 0 || b == xdec_pkg::OP_ESC);
		return b;
	endfunction

	// one instruction with random content; a random ModRM may hit a reserved subcode
	task automatic send_instruction();
		logic [7:0] op, m, s;
		int k;
		if ($urandom_range(9) == 0) begin
			send_byte(xdec_pkg::OP_ESC);
			op = $urandom_range(1) ? xdec_pkg::OP_IMUL2 : {4'h8, 4'($urandom_range(15))};
			send_byte(op);
			k = op == xdec_pkg::OP_IMUL2 ? xdec_pkg::K_IMUL_RM : xdec_pkg::K_JCC_N;
		end else begin
			op = random_opcode();
			send_byte(op);
			k = first_kind(op);
		end
		if (has_modrm(5'(k))) begin
			m = 8'($urandom_range(255));
			send_byte(m);
			if (dp_phase == xdec_pkg::PH_SIB) begin
				s = 8'($urandom_range(255));
				if ($urandom_range(3) == 0) s[2:0] = 3'd5;
				send_byte(s);
			end
		end
		if (dp_phase == xdec_pkg::PH_DISP) send_field(dp_left, $urandom);
		if (dp_phase == xdec_pkg::PH_IMM) send_field(dp_left, $urandom);
	endtask

	// stop offering bytes until every expected record has come
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_records.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	// directed stimulus: bytes, and a glance-checkable kind for the final byte
	typedef struct {
		logic [7:0] b;
		bad_kind_t bad_kind;
	} stim_row_t;

	stim_row_t directed_rows[] = '{
		'{8'h0f, BAD_NONE}, '{8'h05, BAD_LEN2},     // unknown byte after escape
		'{8'hd6, BAD_LEN1},                         // byte that cannot start
		'{8'hc6, BAD_NONE}, '{8'h08, BAD_LEN2},     // MOV with reserved subcode
		'{8'hff, BAD_NONE}, '{8'h38, BAD_LEN2},     // group 5 reserved
		'{8'h90, BAD_NONE},
		'{8'h00, BAD_NONE}, '{8'h00, BAD_NONE},
		'{8'h8b, BAD_NONE}, '{8'h84, BAD_NONE}, '{8'h25, BAD_NONE},
		'{8'h01, BAD_NONE}, '{8'h02, BAD_NONE}, '{8'h03, BAD_NONE}, '{8'h84, BAD_NONE},
		'{8'h7f, BAD_NONE}, '{8'h80, BAD_NONE},     // short branch, negative
		'{8'hc2, BAD_NONE}, '{8'hff, BAD_NONE}, '{8'hff, BAD_NONE},
		'{8'hd1, BAD_NONE}, '{8'hc0, BAD_NONE},     // shift by one
		'{8'h61, BAD_NONE}
	};

	// receiver: random stalls, and a long hold-off counted here on request
	initial begin
		out_stall = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (60) @(negedge clk);
			end else begin
				out_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
			end
		end
	end

	// compare records as they are accepted
	initial begin
		inst_rec_t e;
		bad_kind_t g;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_records.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected record kind %0d", inst_kind);
				end else begin
					e = expected_records.pop_front();
					g = expected_bad_kinds.pop_front();
					if ((g == BAD_LEN1 && !(e.bad && e.len == 4'd1)) ||
							(g == BAD_LEN2 && !(e.bad && e.len == 4'd2))) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp bad record of kind %0d got bad%0d l%0d",
								g, e.bad, e.len);
					end
					if (inst_kind !== e.kind || sub_op !== e.sub || operand_wide !== e.wide ||
							reg_field !== e.reg_f || mod_field !== e.mod_f ||
							rm_field !== e.rm_f || has_sib !== e.has_sib ||
							sib_byte !== e.sib || displacement !== e.disp ||
							immediate !== e.imm || inst_length !== e.len ||
							bad_opcode !== e.bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp k%0d s%0d w%0d r%0d m%0d rm%0d sb%0d %h",
								" d%h i%h l%0d b%0d"},
								e.kind, e.sub, e.wide, e.reg_f, e.mod_f, e.rm_f, e.has_sib,
								e.sib, e.disp, e.imm, e.len, e.bad);
						if (mismatches <= 10)
							$display({"         got k%0d s%0d w%0d r%0d m%0d rm%0d sb%0d %h",
								" d%h i%h l%0d b%0d"},
								inst_kind, sub_op, operand_wide, reg_field, mod_field, rm_field,
								has_sib, sib_byte, displacement, immediate, inst_length,
								bad_opcode);
					end
				end
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("FAIL x86_subset_instruction_decoder");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		code_byte = 8'h00;
		arst_n = 1'b0;
		hold_request = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		dp_phase = xdec_pkg::PH_OP;
		dp_op = '0; dp_modrm = '0; dp_sib = '0; dp_disp = '0; dp_imm = '0;
		dp_left = '0; dp_len = '0; dp_kind = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		foreach (directed_rows[i]) send_byte(directed_rows[i].b, directed_rows[i].bad_kind);
		drain();

		// random part in three idling phases
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = p == 0 ? 21 : (p == 1 ? 57 : 0);
			recv_idle_pct = p == 0 ? 57 : (p == 1 ? 21 : 0);
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
				else send_instruction();
				if (p == 2 && n == 100) begin
					// hold the receiver off while bytes keep coming
					hold_request = 1'b1;
					repeat (8) send_instruction();
					drain();
				end
			end
			// finish any partial instruction, then pause until all records arrive
			while (dp_phase != xdec_pkg::PH_OP) send_byte(8'($urandom_range(255)));
			drain();
		end

		if (mismatches == 0 && expected_records.size() == 0) begin
			$display("PASS x86_subset_instruction_decoder");
		end else begin
			$display("FAIL x86_subset_instruction_decoder");
		end
		$finish;
	end

endmodule
